>>> sv/gdn_pkg.sv
package gdn_pkg;

   // days from 0001-01-01 to 2000-01-01
   localparam int DAYS_TO_2000 = 730119;

   localparam logic       KIND_DATE  = 1'b0;
   localparam logic       KIND_DAYNO = 1'b1;
   localparam logic [3:0] LAST_MONTH = 4'd12;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ACC,
      ST_MSUM,
      ST_WALK,
      ST_DONE
   } state_type;

   // divisions run by the shared subtractor
   typedef enum logic [2:0] {
      DIV_Y100,
      DIV_Q400,
      DIV_Q100,
      DIV_Q4,
      DIV_Q1
   } div_sel_type;

   function automatic logic [21:0] div_divisor(input div_sel_type sel);
      logic [21:0] d;
      case (sel)
         DIV_Y100: d = 22'd100;
         DIV_Q400: d = 22'd146097;
         DIV_Q100: d = 22'd36524;
         DIV_Q4:   d = 22'd1461;
         DIV_Q1:   d = 22'd365;
         default:  d = 22'd1;
      endcase
      return d;
   endfunction

   // years per quotient unit
   function automatic logic [13:0] div_ystep(input div_sel_type sel);
      logic [13:0] s;
      case (sel)
         DIV_Q400: s = 14'd400;
         DIV_Q100: s = 14'd100;
         DIV_Q4:   s = 14'd4;
         DIV_Q1:   s = 14'd1;
         default:  s = 14'd0;
      endcase
      return s;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] n;
      case (month) inside
         4'd2:                    n = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
         default:                 n = 5'd31;
      endcase
      return n;
   endfunction

endpackage

>>> sv/gregorian_day_number_converter_top.sv
// Gregorian date <-> day number converter (day 0 is 2000-01-01).
//
// Request channel (req_*): one beat carries kind and the operands. Kind 0
// checks year/month/day_of_month and returns the day number; kind 1 takes
// day_number and returns year/month/day. Response channel (rsp_*): one beat
// per request with valid_res, day number, date and leap flag; every field
// other than valid_res reads zero when valid_res is low.
//
// One request is in flight at a time: req_ready is high only while idle.
// A single add/subtract unit does the remainder arithmetic under a small
// sequencer: restoring division (one quotient bit a cycle), the day-count
// sum and the month walk (one month a cycle).
//   kind 0: divide the year by 100, sum the day count, walk the months
//   kind 1: divide by 400-, 100-, 4- and 1-year blocks, walk the months
// Bad fields or an out-of-range day number answer straight from idle, a day
// past the month end once the year division is done.
// A stalled response simply holds; the next request is taken once the
// response beat completes. Synchronous reset returns the sequencer to idle
// with no response pending; no state survives between requests.
module gregorian_day_number_converter_top
   import gdn_pkg::*;
#(
   parameter int MAX_YEAR = 9999
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [13:0]        req_year,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day_of_month,
   input  logic signed [22:0] req_day_number,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_valid_res,
   output logic signed [22:0] rsp_out_day_number,
   output logic [13:0]        rsp_out_year,
   output logic [3:0]         rsp_out_month,
   output logic [4:0]         rsp_out_day,
   output logic               rsp_leap_year
);

   // last valid day number: 31 December of MAX_YEAR
   localparam int DN_HI_INT = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                              + MAX_YEAR / 400 - DAYS_TO_2000 - 1;
   localparam logic signed [23:0] DN_HI   = 24'(DN_HI_INT);
   localparam logic signed [23:0] DN_LO   = -24'(DAYS_TO_2000);
   localparam logic [13:0]        YEAR_HI = 14'(MAX_YEAR);

   state_type   state_ff, state_in;
   div_sel_type sel_ff, sel_in;
   logic [2:0]  bit_ff, bit_in;     // current quotient bit
   logic [23:0] rem_ff, rem_in;     // working remainder / accumulator
   logic [7:0]  quo_ff, quo_in;
   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [3:0]  marg_ff, marg_in;   // requested month (kind 0)
   logic [4:0]  day_ff, day_in;
   logic signed [22:0] dn_ff, dn_in;
   logic        leap_ff, leap_in;
   logic        cen_ff, cen_in;     // hundreds quotient is 3
   logic        q4c_ff, q4c_in;     // four-year quotient is 24
   logic        ok_ff, ok_in;
   logic [1:0]  step_ff, step_in;

   // shared add/subtract unit
   logic [23:0] alu_a, alu_b, alu_sum;
   logic        alu_sub;
   logic [13:0] p_w;

   logic signed [23:0] dn_ext;
   logic        date_ok, dn_ok, take, leap_now;
   logic [23:0] rem_next;
   logic [7:0]  quo_next;

   assign p_w    = year_ff - 14'd1;
   assign dn_ext = {req_day_number[22], req_day_number};
   assign dn_ok  = (dn_ext >= DN_LO) && (dn_ext <= DN_HI);
   assign date_ok = (req_year != 14'd0) && (req_year <= YEAR_HI) &&
                    (req_month != 4'd0) && (req_month <= LAST_MONTH) &&
                    (req_day_of_month != 5'd0);

   always_comb begin
      alu_a   = rem_ff;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            alu_a = dn_ext;
            alu_b = 24'(DAYS_TO_2000);
         end
         ST_DIV: begin
            alu_b   = {2'b00, div_divisor(sel_ff)} << bit_ff;
            alu_sub = 1'b1;
         end
         ST_ACC: begin
            case (step_ff)
               2'd0: alu_b = 24'(p_w) * 24'd365;
               2'd1: alu_b = {10'b0, p_w >> 2};
               2'd2: begin
                  alu_b   = {16'b0, quo_ff};
                  alu_sub = 1'b1;
               end
               default: alu_b = {16'b0, quo_ff >> 2};
            endcase
         end
         ST_MSUM: alu_b = {19'b0, month_len(month_ff, leap_ff)};
         ST_WALK: begin
            alu_b   = {19'b0, month_len(month_ff, leap_ff)};
            alu_sub = 1'b1;
         end
         default: alu_b = '0;
      endcase
   end

   assign alu_sum  = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign take     = ~alu_sum[23];
   assign rem_next = take ? alu_sum : rem_ff;
   assign quo_next = {quo_ff[6:0], take};
   // leap test of kind 0 from y/100 and y%100
   assign leap_now = (year_ff[1:0] == 2'd0) &&
                     ((rem_next != 24'd0) || (quo_next[1:0] == 2'd0));

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      year_in  = year_ff;
      month_in = month_ff;
      marg_in  = marg_ff;
      day_in   = day_ff;
      dn_in    = dn_ff;
      leap_in  = leap_ff;
      cen_in   = cen_ff;
      q4c_in   = q4c_ff;
      ok_in    = ok_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               marg_in = req_month;
               day_in  = req_day_of_month;
               dn_in   = req_day_number;
               ok_in   = 1'b0;
               quo_in  = '0;
               if (req_kind == KIND_DATE) begin
                  year_in  = req_year;
                  rem_in   = {10'b0, req_year};
                  sel_in   = DIV_Y100;
                  bit_in   = 3'd7;
                  state_in = date_ok ? ST_DIV : ST_DONE;
               end else begin
                  year_in  = 14'd1;
                  rem_in   = alu_sum;    // days since 0001-01-01
                  sel_in   = DIV_Q400;
                  bit_in   = 3'd4;
                  state_in = dn_ok ? ST_DIV : ST_DONE;
               end
            end
         end
         ST_DIV: begin
            rem_in  = rem_next;
            quo_in  = quo_next;
            year_in = year_ff + (take ? (div_ystep(sel_ff) << bit_ff) : 14'd0);
            if (bit_ff != 3'd0) begin
               bit_in = bit_ff - 3'd1;
            end else begin
               case (sel_ff)
                  DIV_Y100: begin
                     leap_in = leap_now;
                     if (day_ff > month_len(marg_ff, leap_now)) begin
                        state_in = ST_DONE;
                     end else begin
                        rem_in   = {19'b0, day_ff} - 24'd1 - 24'(DAYS_TO_2000);
                        // (y-1)/100
                        quo_in   = (rem_next == 24'd0) ? (quo_next - 8'd1) : quo_next;
                        step_in  = 2'd0;
                        state_in = ST_ACC;
                     end
                  end
                  DIV_Q400: begin
                     sel_in = DIV_Q100;
                     bit_in = 3'd1;
                     quo_in = '0;
                  end
                  DIV_Q100: begin
                     cen_in = (quo_next[1:0] == 2'd3);
                     sel_in = DIV_Q4;
                     bit_in = 3'd4;
                     quo_in = '0;
                  end
                  DIV_Q4: begin
                     q4c_in = (quo_next[4:0] == 5'd24);
                     sel_in = DIV_Q1;
                     bit_in = 3'd1;
                     quo_in = '0;
                  end
                  DIV_Q1: begin
                     leap_in  = (quo_next[1:0] == 2'd3) && (!q4c_ff || cen_ff);
                     month_in = 4'd1;
                     state_in = ST_WALK;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ACC: begin
            rem_in  = alu_sum;
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               month_in = 4'd1;
               state_in = ST_MSUM;
            end
         end
         ST_MSUM: begin
            if (month_ff < marg_ff) begin
               rem_in   = alu_sum;
               month_in = month_ff + 4'd1;
            end else begin
               dn_in    = rem_ff[22:0];
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_WALK: begin
            if ((month_ff < LAST_MONTH) && take) begin
               rem_in   = alu_sum;
               month_in = month_ff + 4'd1;
            end else begin
               day_in   = rem_ff[4:0] + 5'd1;
               ok_in    = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff   <= sel_in;
      bit_ff   <= bit_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      marg_ff  <= marg_in;
      day_ff   <= day_in;
      dn_ff    <= dn_in;
      leap_ff  <= leap_in;
      cen_ff   <= cen_in;
      q4c_ff   <= q4c_in;
      ok_ff    <= ok_in;
      step_ff  <= step_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = (state_ff == ST_DONE);
   assign rsp_valid_res      = ok_ff;
   assign rsp_out_day_number = ok_ff ? dn_ff : 23'sd0;
   assign rsp_out_year       = ok_ff ? year_ff : 14'd0;
   assign rsp_out_month      = ok_ff ? month_ff : 4'd0;
   assign rsp_out_day        = ok_ff ? day_ff : 5'd0;
   assign rsp_leap_year      = ok_ff & leap_ff;

endmodule

>>> sv/gdn_checker.sv
module gdn_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_valid_res,
   input logic signed [22:0] rsp_out_day_number,
   input logic [13:0]        rsp_out_year,
   input logic [3:0]         rsp_out_month,
   input logic [4:0]         rsp_out_day,
   input logic               rsp_leap_year
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_day_number) &&
      $stable(rsp_out_year) && $stable(rsp_out_month) && $stable(rsp_out_day))
      else $error("response changed while stalled");

   // one request in flight
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("response pending while idle");

   // rejected beat carries zeros
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_out_day_number == 23'sd0 &&
      rsp_out_year == 14'd0 && rsp_out_month == 4'd0 && rsp_out_day == 5'd0 &&
      !rsp_leap_year)
      else $error("invalid response not cleared");

   a_valid_date: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_out_month != 4'd0 && rsp_out_month <= 4'd12 &&
      rsp_out_day != 5'd0 && rsp_out_year != 14'd0)
      else $error("valid response with impossible date");

endmodule

bind gregorian_day_number_converter_top gdn_checker u_gdn_checker (.*);

>>> test/tb.sv
module tb
   import gdn_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // year ceiling given to the block
   localparam int MAX_YR = 9999;
   // cycles with no beat on either channel before the run is abandoned
   localparam int STALL_LIMIT = 2000;
   // receiver hold-off used to back the block up into its request side
   localparam int PRESSURE_CYCLES = 60;
   localparam int RANDOM_ITEMS = 680;
   // tail of the random part that runs with no idling at all
   localparam int QUIET_TAIL = 100;
   // cycles allowed after the last response before the verdict
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_PRINTS = 50;

   typedef struct packed {
      logic               kind;
      logic [13:0]        year;
      logic [3:0]         month;
      logic [4:0]         dom;
      logic signed [22:0] day_number;
   } conv_req_type;

   typedef struct packed {
      logic               valid_res;
      logic signed [22:0] day_number;
      logic [13:0]        year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic               leap;
   } conv_result_type;

   // one row of the directed part; fixed rows carry a hand-written answer
   typedef struct packed {
      conv_req_type    req;
      logic            fixed;
      conv_result_type answer;
   } date_row_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_kind;
   logic [13:0]        req_year;
   logic [3:0]         req_month;
   logic [4:0]         req_day_of_month;
   logic signed [22:0] req_day_number;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_valid_res;
   logic signed [22:0] rsp_out_day_number;
   logic [13:0]        rsp_out_year;
   logic [3:0]         rsp_out_month;
   logic [4:0]         rsp_out_day;
   logic               rsp_leap_year;

   conv_result_type pending_results[$];
   date_row_type    directed_rows[$];
   conv_result_type offered_answer;   // answer for the request now on the bus

   int  mismatch_count;
   int  rsp_beats;
   bit  idle_on;        // random idling on both sides
   bit  pressure_req;   // asks the receiver for one long hold-off
   int  hold_left;

   gregorian_day_number_converter_top #(
      .MAX_YEAR(MAX_YR)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_year           (req_year),
      .req_month          (req_month),
      .req_day_of_month   (req_day_of_month),
      .req_day_number     (req_day_number),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_valid_res      (rsp_valid_res),
      .rsp_out_day_number (rsp_out_day_number),
      .rsp_out_year       (rsp_out_year),
      .rsp_out_month      (rsp_out_month),
      .rsp_out_day        (rsp_out_day),
      .rsp_leap_year      (rsp_leap_year)
   );

   // ---------------------------------------------------------------
   // Calendar arithmetic for the prediction
   // ---------------------------------------------------------------

   // divisible by 4, but centuries only when divisible by 400
   function automatic bit is_leap(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int month_length(input int y, input int m);
      case (m)
         2:             return is_leap(y) ? 29 : 28;
         4, 6, 9, 11:   return 30;
         default:       return 31;
      endcase
   endfunction

   // days from 0001-01-01 up to 1 January of year y
   function automatic int days_to_year(input int y);
      int p;
      p = y - 1;
      return 365 * p + p / 4 - p / 100 + p / 400;
   endfunction

   // signed day count of a valid date, 2000-01-01 being day 0
   function automatic int day_index(input int y, input int m, input int d);
      int n;
      n = d - 1;
      for (int k = 1; k < m; k++) n += month_length(y, k);
      return days_to_year(y) + n - days_to_year(2000);
   endfunction

   function automatic conv_result_type predict_conversion(input conv_req_type rq);
      conv_result_type res;
      int y, m, d, n, rem, lo, hi, q400, q100, q4, q1;
      res = '0;
      if (rq.kind == KIND_DATE) begin
         y = int'(rq.year);
         m = int'(rq.month);
         d = int'(rq.dom);
         if (y >= 1 && y <= MAX_YR && m >= 1 && m <= 12 &&
             d >= 1 && d <= month_length(y, m)) begin
            res.valid_res  = 1'b1;
            res.day_number = 23'(day_index(y, m, d));
            res.year       = 14'(y);
            res.month      = 4'(m);
            res.day        = 5'(d);
            res.leap       = is_leap(y);
         end
      end else begin
         n  = int'(rq.day_number);
         lo = -days_to_year(2000);
         hi = day_index(MAX_YR, 12, 31);
         if (n >= lo && n <= hi) begin
            // peel off 400-, 100-, 4- and 1-year blocks, then walk months
            rem  = n - lo;
            q400 = rem / 146097;
            rem  = rem % 146097;
            q100 = rem / 36524;
            if (q100 > 3) q100 = 3;
            rem -= q100 * 36524;
            q4   = rem / 1461;
            rem -= q4 * 1461;
            q1   = rem / 365;
            if (q1 > 3) q1 = 3;
            rem -= q1 * 365;
            y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
            m = 1;
            while (m < 12 && rem >= month_length(y, m)) begin
               rem -= month_length(y, m);
               m++;
            end
            res.valid_res  = 1'b1;
            res.day_number = 23'(n);
            res.year       = 14'(y);
            res.month      = 4'(m);
            res.day        = 5'(rem + 1);
            res.leap       = is_leap(y);
         end
      end
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------

   // unused day number held at all ones
   function automatic conv_req_type date_req(input int y, input int m, input int d);
      conv_req_type rq;
      rq.kind       = KIND_DATE;
      rq.year       = 14'(y);
      rq.month      = 4'(m);
      rq.dom        = 5'(d);
      rq.day_number = '1;
      return rq;
   endfunction

   // unused date fields held at all ones
   function automatic conv_req_type dayno_req(input int n);
      conv_req_type rq;
      rq.kind       = KIND_DAYNO;
      rq.year       = '1;
      rq.month      = '1;
      rq.dom        = '1;
      rq.day_number = 23'(n);
      return rq;
   endfunction

   function automatic conv_result_type good_date(input int n, input int y, input int m,
                                                 input int d, input bit lp);
      conv_result_type r;
      r.valid_res  = 1'b1;
      r.day_number = 23'(n);
      r.year       = 14'(y);
      r.month      = 4'(m);
      r.day        = 5'(d);
      r.leap       = lp;
      return r;
   endfunction

   task automatic add_row(input conv_req_type rq, input bit fixed,
                          input conv_result_type r);
      date_row_type row;
      row.req    = rq;
      row.fixed  = fixed;
      row.answer = r;
      directed_rows.push_back(row);
   endtask

   // mostly well-formed dates and in-range day numbers, some noise
   function automatic conv_req_type random_req();
      conv_req_type rq;
      int pick, y, m;
      int edge_years[13] = '{1, 2, 3, 4, 99, 100, 399, 400, 1600, 1900, 2000, 9996,
                             MAX_YR};
      rq.kind       = 1'($urandom());
      rq.year       = 14'($urandom());
      rq.month      = 4'($urandom());
      rq.dom        = 5'($urandom());
      rq.day_number = 23'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         rq.kind = KIND_DATE;
         if ($urandom_range(0, 9) == 0)
            y = edge_years[$urandom_range(0, 12)];
         else
            y = $urandom_range(1, MAX_YR);
         m = $urandom_range(1, 12);
         rq.year  = 14'(y);
         rq.month = 4'(m);
         if ($urandom_range(0, 3) == 0)
            rq.dom = 5'(month_length(y, m));
         else
            rq.dom = 5'($urandom_range(1, month_length(y, m)));
      end else if (pick < 80) begin
         rq.kind = KIND_DAYNO;
         rq.day_number = 23'(int'($urandom_range(0, day_index(MAX_YR, 12, 31)
                                                   + days_to_year(2000)))
                             - days_to_year(2000));
      end else if (pick < 90) begin
         rq.kind = KIND_DATE;
         if ($urandom_range(0, 1) == 0) rq.year = 14'($urandom_range(0, MAX_YR));
      end else begin
         rq.kind = KIND_DAYNO;
      end
      return rq;
   endfunction

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTS) $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] got,
                              input logic signed [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s got %0d want %0d",
                                   rsp_beats, name, got, want));
   endtask

   // responses are compared before the request of the same edge is queued
   always @(posedge clock) begin
      conv_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("beat %0d arrived with nothing pending",
                                         rsp_beats));
            end else begin
               want = pending_results.pop_front();
               check_field("valid_res", 32'(rsp_valid_res), 32'(want.valid_res));
               check_field("day_number", 32'(rsp_out_day_number),
                           32'(want.day_number));
               check_field("year", 32'(rsp_out_year), 32'(want.year));
               check_field("month", 32'(rsp_out_month), 32'(want.month));
               check_field("day", 32'(rsp_out_day), 32'(want.day));
               check_field("leap_year", 32'(rsp_leap_year), 32'(want.leap));
            end
            rsp_beats++;
         end
         if (req_valid && req_ready) pending_results.push_back(offered_answer);
      end
   end

   // ---------------------------------------------------------------
   // Clock, reset and watchdog
   // ---------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // counts cycles with no beat on either side; hitting the limit ends the run
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------
   // Receiver: random short stalls, plus one long hold-off on request
   // ---------------------------------------------------------------

   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (pressure_req) begin
            // long stall so the block backs up and drops req_ready
            pressure_req = 1'b0;
            hold_left    = PRESSURE_CYCLES - 1;
            rsp_ready   <= 1'b0;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            hold_left  = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------

   // puts one request on the bus and returns at the edge that takes it
   task automatic send_req(input conv_req_type rq, input conv_result_type answer);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= rq.kind;
      req_year         <= rq.year;
      req_month        <= rq.month;
      req_day_of_month <= rq.dom;
      req_day_number   <= rq.day_number;
      offered_answer    = answer;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
   endtask

   initial begin
      conv_req_type rq;
      conv_result_type bad;

      bad              = '0;
      mismatch_count   = 0;
      rsp_beats        = 0;
      idle_on          = 1'b0;
      pressure_req     = 1'b0;
      offered_answer   = '0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_DATE;
      req_year         = '0;
      req_month        = '0;
      req_day_of_month = '0;
      req_day_number   = '0;

      // extremes, bad fields, leap rules, day-number bounds
      add_row(date_req(2000, 1, 1), 1, good_date(0, 2000, 1, 1, 1));
      add_row(date_req(1, 1, 1), 1, good_date(-730119, 1, 1, 1, 0));
      add_row(date_req(MAX_YR, 12, 31), 1, good_date(2921939, MAX_YR, 12, 31, 0));
      add_row(date_req(0, 1, 1), 1, bad);               // year zero
      add_row(date_req(MAX_YR + 1, 1, 1), 1, bad);      // just past the year limit
      add_row(date_req(16383, 15, 31), 1, bad);         // every field at its top
      add_row(date_req(2021, 0, 10), 1, bad);
      add_row(date_req(2021, 13, 10), 1, bad);
      add_row(date_req(2021, 15, 1), 1, bad);
      add_row(date_req(2021, 6, 0), 1, bad);
      add_row(date_req(2021, 4, 31), 1, bad);
      add_row(date_req(2001, 2, 29), 1, bad);
      add_row(date_req(1900, 2, 29), 1, bad);           // century, not leap
      add_row(date_req(2000, 2, 30), 1, bad);
      add_row(date_req(2000, 2, 29), 0, bad);
      add_row(date_req(2024, 12, 31), 0, bad);
      add_row(dayno_req(0), 1, good_date(0, 2000, 1, 1, 1));
      add_row(dayno_req(-1), 1, good_date(-1, 1999, 12, 31, 0));
      add_row(dayno_req(-730119), 1, good_date(-730119, 1, 1, 1, 0));
      add_row(dayno_req(-730120), 1, bad);
      add_row(dayno_req(2921939), 1, good_date(2921939, MAX_YR, 12, 31, 0));
      add_row(dayno_req(2921940), 1, bad);
      add_row(dayno_req(4194303), 1, bad);
      add_row(dayno_req(-4194304), 1, bad);
      add_row(dayno_req(59), 0, bad);
      add_row(dayno_req(366), 0, bad);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_on = 1'b1;
      foreach (directed_rows[i]) begin
         rq = directed_rows[i].req;
         send_req(rq, directed_rows[i].fixed ? directed_rows[i].answer
                                             : predict_conversion(rq));
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // a stretch with no idling mid-run, and a quiet tail
         idle_on = !((i >= 300 && i < 350) || i >= RANDOM_ITEMS - QUIET_TAIL);
         if (i == 150) pressure_req = 1'b1;
         rq = random_req();
         send_req(rq, predict_conversion(rq));
      end

      @(negedge clock);
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
